### hw/rtl/gcenc_pkg.sv
// Shared types, constants and functions for the Golomb encoder.
package gcenc_pkg;

	localparam int VALUE_BITS  = 16;
	localparam int DIV_W       = 16;
	localparam int CHUNK_BITS  = 32;
	localparam int MAX_CHUNKS  = 64;
	localparam int LEN_W       = 6;
	localparam int BUDGET      = MAX_CHUNKS * CHUNK_BITS;
	localparam int REM_W       = $clog2(BUDGET + 1);
	localparam int NB_W        = $clog2(DIV_W + 1);
	localparam int TAIL_W      = DIV_W + 1;
	localparam int TOTAL_W     = VALUE_BITS + 2;
	localparam int RADIX_BITS  = 4;
	localparam int DIV_CYCLES  = VALUE_BITS / RADIX_BITS;
	localparam int CNT_W       = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
	localparam int FIFO_DEPTH  = 2;
	localparam int PTR_W       = $clog2(FIFO_DEPTH);
	localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam logic [DIV_W-1:0] DIVISOR_RST = DIV_W'(4);

	// One codeword: overflow flag, the end mark and remainder bits as one word, plus its length.
	typedef struct packed {
		logic              ovf;
		logic [TAIL_W-1:0] tail;
		logic [REM_W-1:0]  total;
	} desc_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_FIN  = 3'b100
	} front_state_t;

	// Smallest b with 2^b >= m.
	function automatic logic [NB_W-1:0] ceil_log2(input logic [DIV_W-1:0] m);
		logic [NB_W-1:0] b;
		b = '0;
		for (int i = DIV_W; i >= 0; i--) begin
			if ((TAIL_W'(1) << i) >= TAIL_W'(m)) begin
				b = NB_W'(i);
			end
		end
		return b;
	endfunction

endpackage

### hw/rtl/golomb_encoder.sv
// Top level of the Golomb encoder with truncated-binary remainder.
// Each value is divided by the divisor register in a restoring divider that
// retires four quotient bits per cycle; the front end takes the next value in
// the cycle that it pushes the codeword it has formed into the queue.
// A two-entry queue holds finished codewords; the back end first loads a
// codeword and then emits one 32-bit chunk per cycle while the output is not
// stalled. A divisor of zero or a codeword over 2048 bits yields one result
// with overflow set.
module golomb_encoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gcenc_pkg::DIV_W-1:0]       divisor,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [gcenc_pkg::VALUE_BITS-1:0]  value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [gcenc_pkg::CHUNK_BITS-1:0]  chunk_bits,
	output logic [gcenc_pkg::LEN_W-1:0]       chunk_length,
	output logic                              last_chunk,
	output logic                              overflow
);
	import gcenc_pkg::*;

	logic  push;
	logic  fifo_full;
	logic  pop;
	logic  head_valid;
	desc_t push_desc;
	desc_t head;

	gcenc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.divisor   (divisor),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.fifo_full (fifo_full),
		.push      (push),
		.push_desc (push_desc)
	);

	gcenc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.full       (fifo_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	gcenc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.chunk_bits   (chunk_bits),
		.chunk_length (chunk_length),
		.last_chunk   (last_chunk),
		.overflow     (overflow)
	);

endmodule

### hw/rtl/gcenc_front.sv
// Front end: divisor register, value intake, radix-16 divider and codeword setup.
module gcenc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gcenc_pkg::DIV_W-1:0]       divisor,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [gcenc_pkg::VALUE_BITS-1:0]  value,
	input  logic                              fifo_full,
	output logic                              push,
	output gcenc_pkg::desc_t                  push_desc
);
	import gcenc_pkg::*;

	front_state_t            state_q;
	logic [DIV_W-1:0]        divisor_q;
	logic [NB_W-1:0]         b_q;
	logic [DIV_W-1:0]        thresh_q;
	logic [VALUE_BITS-1:0]   quot_q;
	logic [DIV_W-1:0]        rem_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    accept;
	logic [VALUE_BITS-1:0]   quot_nx;
	logic [DIV_W-1:0]        rem_nx;
	logic [TAIL_W-1:0]       t_w;
	logic                    below;
	logic [DIV_W-1:0]        code;
	logic [NB_W-1:0]         nbits;
	logic [TOTAL_W-1:0]      total;
	logic [NB_W-1:0]         b_new;

	assign cfg_ready = 1'b1;
	assign b_new     = ceil_log2(divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= DIVISOR_RST;
			b_q       <= ceil_log2(DIVISOR_RST);
			thresh_q  <= DIV_W'((TAIL_W'(1) << ceil_log2(DIVISOR_RST)) - TAIL_W'(DIVISOR_RST));
		end else if (cfg_valid) begin
			divisor_q <= divisor;
			b_q       <= b_new;
			thresh_q  <= DIV_W'((TAIL_W'(1) << b_new) - TAIL_W'(divisor));
		end
	end

	// Four restoring steps per cycle.
	always_comb begin
		quot_nx = quot_q;
		rem_nx  = rem_q;
		t_w     = '0;
		for (int i = 0; i < RADIX_BITS; i++) begin
			t_w     = {rem_nx, quot_nx[VALUE_BITS-1]};
			quot_nx = {quot_nx[VALUE_BITS-2:0], 1'b0};
			if (t_w >= TAIL_W'(divisor_q)) begin
				rem_nx     = DIV_W'(t_w - TAIL_W'(divisor_q));
				quot_nx[0] = 1'b1;
			end else begin
				rem_nx = t_w[DIV_W-1:0];
			end
		end
	end

	assign below = rem_q < thresh_q;
	assign code  = below ? rem_q : DIV_W'(rem_q + thresh_q);
	assign nbits = below ? NB_W'(b_q - NB_W'(1)) : b_q;
	assign total = TOTAL_W'(quot_q) + TOTAL_W'(1) + TOTAL_W'(nbits);

	always_comb begin
		push_desc.ovf   = (divisor_q == '0) || (total > TOTAL_W'(BUDGET));
		push_desc.tail  = TAIL_W'(code) | (TAIL_W'(1) << nbits);
		push_desc.total = total[REM_W-1:0];
	end

	assign push     = (state_q == S_FIN) && !fifo_full;
	assign in_ready = (state_q == S_IDLE) || push;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DIV;
						cnt_q   <= '0;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DIV_CYCLES - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (accept) begin
						state_q <= S_DIV;
						cnt_q   <= '0;
					end else if (push) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			quot_q <= value;
			rem_q  <= '0;
		end else if (state_q == S_DIV) begin
			quot_q <= quot_nx;
			rem_q  <= rem_nx;
		end
	end

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == CNT_W'(DIV_CYCLES - 1)) |=> (state_q == S_FIN))
		else $error("divider did not finish on time");

endmodule

### hw/rtl/gcenc_fifo.sv
// Two-entry queue of codeword descriptors between front and back.
module gcenc_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gcenc_pkg::desc_t  push_desc,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output gcenc_pkg::desc_t  head
);
	import gcenc_pkg::*;

	desc_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FCNT_W-1:0] count_q;

	assign full       = count_q == FCNT_W'(FIFO_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PTR_W'((int'(wr_ptr_q) + 1) % FIFO_DEPTH);
			end
			if (pop) begin
				rd_ptr_q <= PTR_W'((int'(rd_ptr_q) + 1) % FIFO_DEPTH);
			end
			if (push && !pop) begin
				count_q <= count_q + FCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FCNT_W'(1);
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("queue read while empty");

endmodule

### hw/rtl/gcenc_back.sv
// Back end: cuts each codeword into chunks and drives the output register.
module gcenc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              head_valid,
	input  gcenc_pkg::desc_t                  head,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [gcenc_pkg::CHUNK_BITS-1:0]  chunk_bits,
	output logic [gcenc_pkg::LEN_W-1:0]       chunk_length,
	output logic                              last_chunk,
	output logic                              overflow
);
	import gcenc_pkg::*;

	localparam int WIDE_W = TAIL_W + CHUNK_BITS;

	logic                   busy_q;
	logic                   ovf_q;
	logic [TAIL_W-1:0]      tail_q;
	logic [REM_W-1:0]       left_q;
	logic                   out_valid_q;
	logic [CHUNK_BITS-1:0]  bits_q;
	logic [LEN_W-1:0]       len_q;
	logic                   last_q;
	logic                   ovf_out_q;
	logic                   fire;
	logic                   is_last;
	logic [WIDE_W-1:0]      wide;

	assign pop     = !busy_q && head_valid;
	assign fire    = busy_q && (!out_valid_q || out_ready);
	assign is_last = ovf_q || (left_q <= REM_W'(CHUNK_BITS));
	assign wide    = {tail_q, CHUNK_BITS'(0)} >> left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (fire && is_last) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ovf_q  <= head.ovf;
			tail_q <= head.tail;
			left_q <= head.total;
		end else if (fire) begin
			left_q <= left_q - REM_W'(CHUNK_BITS);
		end
		if (fire) begin
			last_q    <= is_last;
			ovf_out_q <= ovf_q;
			if (ovf_q) begin
				bits_q <= '0;
				len_q  <= '0;
			end else begin
				bits_q <= wide[CHUNK_BITS-1:0];
				len_q  <= is_last ? LEN_W'(left_q) : LEN_W'(CHUNK_BITS);
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign chunk_bits   = bits_q;
	assign chunk_length = len_q;
	assign last_chunk   = last_q;
	assign overflow     = ovf_out_q;

	a_ovf_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ovf_out_q) |-> (last_q && len_q == '0 && bits_q == '0))
		else $error("overflow result carries bits");
	a_full_middle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> (len_q == LEN_W'(CHUNK_BITS) && !ovf_out_q))
		else $error("inner chunk not full");
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !ovf_out_q) |-> (len_q != '0))
		else $error("empty chunk emitted");

endmodule
